@@ rtl/clnf_pkg.sv @@
// ----------------------------------------------------------------------------
// Character LCD number formatter package
// Request and result types, mode codes and display constants shared by the
// formatter modules.
// ----------------------------------------------------------------------------
package clnf_pkg;

	localparam logic [2:0] MODE_CHAR = 3'd0;
	localparam logic [2:0] MODE_UDEC = 3'd1;
	localparam logic [2:0] MODE_SDEC = 3'd2;
	localparam logic [2:0] MODE_HEX  = 3'd3;
	localparam logic [2:0] MODE_BIN  = 3'd4;

	localparam logic [1:0] LINE_FIRST = 2'd1;

	localparam logic [7:0] LCD_SET_ADDR = 8'h80;
	localparam logic [7:0] LCD_LINE2    = 8'h40;
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_ALPHA  = 8'h37;
	localparam logic [7:0] ASCII_PLUS   = 8'h2B;
	localparam logic [7:0] ASCII_MINUS  = 8'h2D;

	localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [1:0]  line_select;
		logic [5:0]  column;
		logic [15:0] value;
		logic [4:0]  digit_count;
	} req_t;

	typedef struct packed {
		logic [7:0] lcd_byte;
		logic       is_data;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] cmd;
		logic       neg;
	} head_t;

	function automatic logic [7:0] digit_to_ascii(input logic [3:0] dig);
		logic [7:0] res;
		if (dig < 4'd10) begin
			res = ASCII_ZERO + {4'b0000, dig};
		end else begin
			res = ASCII_ALPHA + {4'b0000, dig};
		end
		return res;
	endfunction

endpackage

@@ rtl/char_lcd_number_formatter_core.sv @@
// ----------------------------------------------------------------------------
// Character LCD number formatter core
// Turns a request into the set-address command followed by the character
// bytes of one number field, one byte per strobe.
// ----------------------------------------------------------------------------
// A request is written to the queue, popped in S_IDLE, and its command byte is emitted in S_CMD
// and registered onto rsp. Char mode then sends one character byte; hexadecimal and binary send
// digit_count digits; decimal converts digit_count digits first (signed mode sends a sign byte before).
// The decimal digits come from the divide-by-ten loop in the back end.
// A two-entry queue lets two more requests wait while one is formatted.
// Reset clears the queue and the sequencer; no byte is sent during reset.
module char_lcd_number_formatter_core #(
	parameter int MAX_DIGITS  = 16,
	parameter int VALUE_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  clnf_pkg::req_t req,
	output logic           busy,
	output logic           strobe,
	output clnf_pkg::rsp_t rsp
);
	import clnf_pkg::*;

	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int DESC_W = $bits(head_t) + VALUE_WIDTH + CNT_W;

	logic                   push;
	logic                   pop;
	logic                   full;
	logic                   empty;
	head_t                  f_head;
	logic [VALUE_WIDTH-1:0] f_mag;
	logic [CNT_W-1:0]       f_cnt;
	head_t                  b_head;
	logic [VALUE_WIDTH-1:0] b_mag;
	logic [CNT_W-1:0]       b_cnt;
	logic [DESC_W-1:0]      wdata;
	logic [DESC_W-1:0]      rdata;

	assign busy  = full;
	assign wdata = {f_head, f_mag, f_cnt};
	assign {b_head, b_mag, b_cnt} = rdata;

	clnf_front #(
		.MAX_DIGITS  (MAX_DIGITS),
		.VALUE_WIDTH (VALUE_WIDTH),
		.CNT_W       (CNT_W)
	) u_front (
		.start (start),
		.req   (req),
		.full  (full),
		.push  (push),
		.head  (f_head),
		.mag   (f_mag),
		.cnt   (f_cnt)
	);

	clnf_queue #(
		.WIDTH (DESC_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.full   (full),
		.empty  (empty)
	);

	clnf_back #(
		.MAX_DIGITS  (MAX_DIGITS),
		.VALUE_WIDTH (VALUE_WIDTH),
		.CNT_W       (CNT_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (b_head),
		.mag    (b_mag),
		.cnt    (b_cnt),
		.pop    (pop),
		.strobe (strobe),
		.rsp    (rsp)
	);

endmodule

@@ rtl/clnf_front.sv @@
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts requests, drops undefined modes, and builds the set-address
// command, the sign and the magnitude for the back end.
// ----------------------------------------------------------------------------
module clnf_front #(
	parameter int MAX_DIGITS  = 16,
	parameter int VALUE_WIDTH = 16,
	parameter int CNT_W       = $clog2(MAX_DIGITS + 1)
) (
	input  logic                   start,
	input  clnf_pkg::req_t         req,
	input  logic                   full,
	output logic                   push,
	output clnf_pkg::head_t        head,
	output logic [VALUE_WIDTH-1:0] mag,
	output logic [CNT_W-1:0]       cnt
);
	import clnf_pkg::*;

	logic                   mode_ok;
	logic [31:0]            val_ext;
	logic [VALUE_WIDTH-1:0] val_m;
	logic [7:0]             addr;
	logic                   neg;

	always_comb begin
		mode_ok = (req.mode == MODE_CHAR) || (req.mode == MODE_UDEC) ||
			(req.mode == MODE_SDEC) || (req.mode == MODE_HEX) || (req.mode == MODE_BIN);
		push = start && !full && mode_ok;

		addr = LCD_SET_ADDR + {2'b00, req.column} - 8'd1;
		if (req.line_select != LINE_FIRST) begin
			addr = addr + LCD_LINE2;
		end

		val_ext = {16'h0000, req.value};
		val_m   = val_ext[VALUE_WIDTH-1:0];
		neg     = val_m[VALUE_WIDTH-1] || (val_m == '0);

		head.mode = req.mode;
		head.cmd  = addr;
		head.neg  = neg;

		if (req.mode == MODE_SDEC && neg) begin
			mag = ~val_m + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
		end else begin
			mag = val_m;
		end

		if (int'(req.digit_count) > MAX_DIGITS) begin
			cnt = CNT_W'(MAX_DIGITS);
		end else begin
			cnt = CNT_W'(req.digit_count);
		end
	end

endmodule

@@ rtl/clnf_queue.sv @@
// ----------------------------------------------------------------------------
// Formatter request queue
// Short first-in first-out buffer that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module clnf_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import clnf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/clnf_back.sv @@
// ----------------------------------------------------------------------------
// Formatter back end
// Sequences the command, character, sign and digit bytes of one request. Decimal
// digits come from a divide-by-ten loop using a reciprocal
// multiply; hexadecimal and binary digits are sliced from the value.
// ----------------------------------------------------------------------------
module clnf_back #(
	parameter int MAX_DIGITS  = 16,
	parameter int VALUE_WIDTH = 16,
	parameter int CNT_W       = $clog2(MAX_DIGITS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   empty,
	input  clnf_pkg::head_t        head,
	input  logic [VALUE_WIDTH-1:0] mag,
	input  logic [CNT_W-1:0]       cnt,
	output logic                   pop,
	output logic                   strobe,
	output clnf_pkg::rsp_t         rsp
);
	import clnf_pkg::*;

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int PW    = VALUE_WIDTH + 32;
	localparam int QW    = PW - RECIP_SHIFT;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CMD  = 7'b0000010,
		S_CHAR = 7'b0000100,
		S_SIGN = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_REM  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t                 state_q, state_d;
	state_t                 after_sign;
	head_t                  head_q;
	logic [VALUE_WIDTH-1:0] work_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       conv_idx_q;
	logic [IDX_W-1:0]       idx_q;
	logic [PW-1:0]          prod_q;
	logic [3:0]             digs_q [MAX_DIGITS];
	logic                   strobe_q;
	rsp_t                   rsp_q, rsp_d;
	logic                   emit;
	logic                   is_dec;
	logic                   cnt_zero;
	logic                   conv_last;
	logic [QW-1:0]          quot;
	logic [VALUE_WIDTH-1:0] qx10;
	logic [VALUE_WIDTH-1:0] rem;
	logic [VALUE_WIDTH-1:0] shifted_h;
	logic [VALUE_WIDTH-1:0] shifted_b;
	logic [3:0]             dig;

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	always_comb begin
		is_dec    = (head_q.mode == MODE_UDEC) || (head_q.mode == MODE_SDEC);
		cnt_zero  = (cnt_q == '0);
		conv_last = (CNT_W'(conv_idx_q) + CNT_W'(1)) == cnt_q;

		quot = prod_q[PW-1:RECIP_SHIFT];
		qx10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
		rem  = work_q - qx10;

		shifted_h = work_q >> {idx_q, 2'b00};
		shifted_b = work_q >> idx_q;
		if (is_dec) begin
			dig = digs_q[idx_q];
		end else if (head_q.mode == MODE_HEX) begin
			dig = shifted_h[3:0];
		end else begin
			dig = {3'b000, shifted_b[0]};
		end

		if (cnt_zero) begin
			after_sign = S_IDLE;
		end else if (is_dec) begin
			after_sign = S_MUL;
		end else begin
			after_sign = S_EMIT;
		end

		state_d = state_q;
		emit    = 1'b0;
		pop     = 1'b0;
		rsp_d   = '0;
		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = S_CMD;
				end
			end
			S_CMD: begin
				emit           = 1'b1;
				rsp_d.lcd_byte = head_q.cmd;
				rsp_d.is_data  = 1'b0;
				rsp_d.last     = (head_q.mode != MODE_CHAR) &&
					(head_q.mode != MODE_SDEC) && cnt_zero;
				if (head_q.mode == MODE_CHAR) begin
					state_d = S_CHAR;
				end else if (head_q.mode == MODE_SDEC) begin
					state_d = S_SIGN;
				end else begin
					state_d = after_sign;
				end
			end
			S_CHAR: begin
				emit           = 1'b1;
				rsp_d.lcd_byte = work_q[7:0];
				rsp_d.is_data  = 1'b1;
				rsp_d.last     = 1'b1;
				state_d        = S_IDLE;
			end
			S_SIGN: begin
				emit           = 1'b1;
				rsp_d.lcd_byte = head_q.neg ? ASCII_MINUS : ASCII_PLUS;
				rsp_d.is_data  = 1'b1;
				rsp_d.last     = cnt_zero;
				state_d        = after_sign;
			end
			S_MUL: begin
				state_d = S_REM;
			end
			S_REM: begin
				state_d = conv_last ? S_EMIT : S_MUL;
			end
			S_EMIT: begin
				emit           = 1'b1;
				rsp_d.lcd_byte = digit_to_ascii(dig);
				rsp_d.is_data  = 1'b1;
				rsp_d.last     = (idx_q == '0);
				if (idx_q == '0) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q     <= head;
			work_q     <= mag;
			cnt_q      <= cnt;
			conv_idx_q <= '0;
		end
		if (state_q == S_MUL) begin
			prod_q <= work_q * RECIP_10;
		end
		if (state_q == S_REM) begin
			digs_q[conv_idx_q] <= rem[3:0];
			work_q             <= VALUE_WIDTH'(quot);
			conv_idx_q         <= conv_idx_q + 1'b1;
		end
		if (state_q == S_EMIT) begin
			idx_q <= idx_q - 1'b1;
		end else if (state_d == S_EMIT) begin
			idx_q <= IDX_W'(cnt_q - 1'b1);
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

@@ dv/tb_char_lcd_number_formatter_core.sv @@
// ----------------------------------------------------------------------------
// Character LCD number formatter core testbench
// Sends formatting requests through the start/busy handshake and predicts
// the set-address command and character bytes of each one. Every strobed
// byte is checked against the oldest predicted byte. Requests come from a
// short directed list followed by random requests, with random start gaps,
// three pauses until all bytes have drained, and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_char_lcd_number_formatter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import clnf_pkg::*;

	localparam int MAX_DIGITS   = 16;
	localparam int VALUE_WIDTH  = 16;
	localparam int RANDOM_ITEMS = 205;
	localparam int QUIET_TAIL   = 25;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		req_t r;
		bit   hold_for_drain;
		bit   gap_ok;
	} lcd_request_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic strobe;
	rsp_t rsp;

	lcd_request_t request_q[$];
	rsp_t         lcd_byte_q[$];
	int           idle_left = 0;
	int           fail_count = 0;
	int           cycle_count = 0;

	char_lcd_number_formatter_core #(
		.MAX_DIGITS(MAX_DIGITS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.strobe(strobe),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic rsp_t lcd_out(input logic [7:0] b, input logic d);
		return rsp_t'({b, d, 1'b0});
	endfunction

	function automatic void predict_lcd_bytes(input req_t r);
		logic [7:0]  addr;
		logic [7:0]  digs[MAX_DIGITS];
		int unsigned mag;
		int unsigned radix;
		int unsigned cnt;
		rsp_t        run[$];
		if (r.mode > MODE_BIN) begin
			return;
		end
		addr = LCD_SET_ADDR + {2'b00, r.column} - 8'd1;
		if (r.line_select != LINE_FIRST) begin
			addr = addr + LCD_LINE2;
		end
		run.push_back(lcd_out(addr, 1'b0));
		if (r.mode == MODE_CHAR) begin
			run.push_back(lcd_out(r.value[7:0], 1'b1));
		end else begin
			cnt = (r.digit_count > MAX_DIGITS) ? MAX_DIGITS : r.digit_count;
			mag = r.value;
			if (r.mode == MODE_SDEC) begin
				if (!r.value[VALUE_WIDTH-1] && r.value != '0) begin
					run.push_back(lcd_out(ASCII_PLUS, 1'b1));
				end else begin
					run.push_back(lcd_out(ASCII_MINUS, 1'b1));
					mag = (~mag + 1) & ((1 << VALUE_WIDTH) - 1);
				end
			end
			radix = (r.mode == MODE_HEX) ? 16 : (r.mode == MODE_BIN) ? 2 : 10;
			for (int i = 0; i < int'(cnt); i++) begin
				digs[i] = 8'(mag % radix);
				mag = mag / radix;
			end
			for (int i = int'(cnt) - 1; i >= 0; i--) begin
				run.push_back(lcd_out((digs[i] < 8'd10) ? ASCII_ZERO + digs[i] :
					ASCII_ALPHA + digs[i], 1'b1));
			end
		end
		run[run.size()-1].last = 1'b1;
		foreach (run[k]) begin
			lcd_byte_q.push_back(run[k]);
		end
	endfunction

	function automatic req_t mk_req(input logic [2:0] mode, input logic [1:0] line_select,
		input logic [5:0] column, input logic [15:0] value, input logic [4:0] digit_count);
		req_t r;
		r.mode        = mode;
		r.line_select = line_select;
		r.column      = column;
		r.value       = value;
		r.digit_count = digit_count;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.mode = ($urandom_range(0, 19) < 2) ? 3'($urandom_range(5, 7)) :
			3'($urandom_range(0, 4));
		r.line_select = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
			2'($urandom_range(1, 2));
		r.column = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) :
			6'($urandom_range(1, 40));
		case ($urandom_range(0, 9))
			0: r.value = 16'h0000;
			1: r.value = 16'hFFFF;
			2: r.value = 16'h8000;
			3: r.value = 16'h7FFF;
			default: r.value = 16'($urandom);
		endcase
		r.digit_count = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, 16));
		return r;
	endfunction

	task automatic add_request(input req_t r, input bit hold, input bit gap_ok);
		lcd_request_t item;
		item.r              = r;
		item.hold_for_drain = hold;
		item.gap_ok         = gap_ok;
		request_q.push_back(item);
	endtask

	always @(posedge clk) begin
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			next_start = 1'b0;
			if (start && !busy) begin
				predict_lcd_bytes(request_q[0].r);
				if (request_q[0].gap_ok && $urandom_range(0, 3) == 0) begin
					idle_left = $urandom_range(1, 15);
				end
				request_q.pop_front();
			end
			if (idle_left > 0) begin
				idle_left--;
			end else if (request_q.size() > 0 &&
				(!request_q[0].hold_for_drain || lcd_byte_q.size() == 0)) begin
				next_start = 1'b1;
				req <= request_q[0].r;
			end
			start <= next_start;
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && strobe) begin
			if (lcd_byte_q.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h/%b/%b",
					$time, rsp.lcd_byte, rsp.is_data, rsp.last);
				fail_count++;
			end else begin
				e = lcd_byte_q.pop_front();
				if (rsp.lcd_byte !== e.lcd_byte || rsp.is_data !== e.is_data ||
					rsp.last !== e.last) begin
					$display("%0t: mismatch, expected %h/%b/%b, actual %h/%b/%b", $time,
						e.lcd_byte, e.is_data, e.last, rsp.lcd_byte, rsp.is_data, rsp.last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_char_lcd_number_formatter_core NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;

		add_request(mk_req(MODE_CHAR, 2'd1, 6'd1, 16'h0041, 5'd0), 1'b0, 1'b0);
		add_request(mk_req(MODE_CHAR, 2'd2, 6'd40, 16'hA5FF, 5'd31), 1'b0, 1'b0);
		add_request(mk_req(MODE_UDEC, 2'd1, 6'd5, 16'hFFFF, 5'd5), 1'b0, 1'b0);
		add_request(mk_req(MODE_UDEC, 2'd2, 6'd2, 16'h0000, 5'd1), 1'b0, 1'b0);
		add_request(mk_req(MODE_UDEC, 2'd1, 6'd3, 16'd12345, 5'd16), 1'b0, 1'b0);
		add_request(mk_req(MODE_UDEC, 2'd1, 6'd4, 16'd999, 5'd0), 1'b0, 1'b0);
		add_request(mk_req(MODE_UDEC, 2'd2, 6'd6, 16'hFFFF, 5'd31), 1'b0, 1'b0);
		add_request(mk_req(MODE_SDEC, 2'd1, 6'd7, 16'h7FFF, 5'd5), 1'b1, 1'b0);
		add_request(mk_req(MODE_SDEC, 2'd2, 6'd8, 16'h8000, 5'd5), 1'b0, 1'b0);
		add_request(mk_req(MODE_SDEC, 2'd1, 6'd9, 16'h0000, 5'd3), 1'b0, 1'b0);
		add_request(mk_req(MODE_SDEC, 2'd2, 6'd10, 16'hFFFF, 5'd2), 1'b0, 1'b0);
		add_request(mk_req(MODE_SDEC, 2'd1, 6'd11, 16'h0001, 5'd0), 1'b0, 1'b0);
		add_request(mk_req(MODE_SDEC, 2'd1, 6'd12, 16'h8000, 5'd16), 1'b0, 1'b0);
		add_request(mk_req(MODE_HEX, 2'd1, 6'd13, 16'hABCD, 5'd4), 1'b0, 1'b0);
		add_request(mk_req(MODE_HEX, 2'd2, 6'd14, 16'h1234, 5'd16), 1'b0, 1'b0);
		add_request(mk_req(MODE_HEX, 2'd1, 6'd15, 16'hFFFF, 5'd0), 1'b0, 1'b0);
		add_request(mk_req(MODE_BIN, 2'd2, 6'd16, 16'hA5A5, 5'd16), 1'b0, 1'b0);
		add_request(mk_req(MODE_BIN, 2'd1, 6'd17, 16'h0001, 5'd20), 1'b0, 1'b0);
		add_request(mk_req(MODE_CHAR, 2'd1, 6'd0, 16'h0030, 5'd1), 1'b0, 1'b0);
		add_request(mk_req(MODE_HEX, 2'd2, 6'd63, 16'h00F0, 5'd2), 1'b0, 1'b0);
		add_request(mk_req(MODE_UDEC, 2'd0, 6'd20, 16'd42, 5'd3), 1'b0, 1'b0);
		add_request(mk_req(MODE_BIN, 2'd3, 6'd21, 16'h5A5A, 5'd8), 1'b0, 1'b0);
		add_request(mk_req(3'd5, 2'd1, 6'd1, 16'h1111, 5'd4), 1'b0, 1'b0);
		add_request(mk_req(3'd6, 2'd2, 6'd2, 16'h2222, 5'd4), 1'b0, 1'b0);
		add_request(mk_req(3'd7, 2'd1, 6'd3, 16'h3333, 5'd4), 1'b0, 1'b0);
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			add_request(random_req(), (k == 80) || (k == 160), k < RANDOM_ITEMS - QUIET_TAIL);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() > 0 || start) @(negedge clk);
		while (lcd_byte_q.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb_char_lcd_number_formatter_core OK");
		end else begin
			$display("tb_char_lcd_number_formatter_core NOT OK");
		end
		$finish;
	end

endmodule
